FILE: design/fcca_pkg.sv
// ----------------------------------------------------------------------------
// fcca_pkg
// shared types and constants for the fat12 cluster chain allocator
// ----------------------------------------------------------------------------
package fcca_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int MAX_CHAIN_DEF     = 64;

  localparam logic [11:0] END_MARK   = 12'hFF8;
  localparam logic [11:0] END_WRITE  = 12'hFFF;
  localparam logic [11:0] FREE_ENTRY = 12'h000;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WALK   = 2'd2;
  localparam logic [1:0] CMD_RESIZE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] CFG_FIRST_SECTOR = 2'd0;
  localparam logic [1:0] CFG_SHIFT        = 2'd1;
  localparam logic [1:0] CFG_LIMIT        = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] cluster_index;
    logic [11:0] entry_in;
    logic [6:0]  cluster_count;
  } in_item_t;

  typedef struct packed {
    logic [11:0] chain_cluster;
    logic [27:0] sector_address;
    logic [11:0] entry_out;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FAT_RD,
    OP_FAT_WR,
    OP_BUF_RD,
    OP_BUF_WR,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic [11:0] fat_addr;
    logic [11:0] fat_data;
    logic [5:0]  buf_addr;
    logic [11:0] buf_data;
    logic [11:0] emit_cluster;
    logic        emit_sector;
    logic [11:0] emit_entry;
    logic [1:0]  emit_status;
    logic        emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [11:0] fat_q;
    logic [11:0] buf_q;
  } dp_sts_t;

endpackage

FILE: design/fat_cluster_chain_allocator.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator
// fat12 table with load, read, chain walk and chain resize commands
// ----------------------------------------------------------------------------
// channel | ports                         | handshake
// in      | start, busy, in_item          | accepted when start && !busy
// out     | out_valid, out_item           | one-cycle strobe, no stall
// cfg     | cfg_valid, cfg_ready, cfg_*   | valid && ready
//
// walk reads the table once per cluster (table read port); resize keeps
// clusters, frees the rest, searches free entries from cluster 2, links the
// chain and emits the results; a new command waits until busy falls
// each result is registered and leaves in the cycle after its emit state; no clearing pass
// results are strobed once and cannot be held off
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator #(
  parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CHAIN     = fcca_pkg::MAX_CHAIN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fcca_pkg::in_item_t  in_item,
  output logic                out_valid,
  output fcca_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [27:0]         cfg_data
);

  fcca_pkg::dp_cmd_t cmd;
  fcca_pkg::dp_sts_t sts;
  logic [12:0]       limit;

  assign cfg_ready = 1'b1;

  fcca_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_CHAIN(MAX_CHAIN)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_item(in_item),
    .busy(busy),
    .cluster_limit(limit),
    .cmd(cmd),
    .sts(sts)
  );

  fcca_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_CHAIN(MAX_CHAIN)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .cfg_we(cfg_valid),
    .cfg_sel(cfg_index),
    .cfg_data(cfg_data),
    .cluster_limit(limit),
    .out_valid(out_valid),
    .out_item(out_item)
  );

endmodule

FILE: design/fcca_datapath.sv
// ----------------------------------------------------------------------------
// fcca_datapath
// fat table and chain buffer memories, config registers, result register
// ----------------------------------------------------------------------------
module fcca_datapath #(
  parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CHAIN     = fcca_pkg::MAX_CHAIN_DEF,
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int BW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fcca_pkg::dp_cmd_t   cmd,
  output fcca_pkg::dp_sts_t   sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_sel,
  input  logic [27:0]         cfg_data,
  output logic [12:0]         cluster_limit,
  output logic                out_valid,
  output fcca_pkg::out_item_t out_item
);

  logic [11:0] fat_mem [TABLE_ENTRIES];
  logic [11:0] buf_mem [MAX_CHAIN];
  logic [11:0] fat_q_r;
  logic [11:0] buf_q_r;
  logic [27:0] first_sector_r;
  logic [2:0]  shift_r;
  logic [12:0] limit_r;
  logic        out_valid_r;
  fcca_pkg::out_item_t out_r;
  logic [27:0] sector_nxt;

  always_ff @(posedge clk) begin
    if (cmd.op == fcca_pkg::OP_FAT_WR) begin
      fat_mem[cmd.fat_addr[AW-1:0]] <= cmd.fat_data;
    end
    fat_q_r <= fat_mem[cmd.fat_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == fcca_pkg::OP_BUF_WR) begin
      buf_mem[cmd.buf_addr[BW-1:0]] <= cmd.buf_data;
    end
    buf_q_r <= buf_mem[cmd.buf_addr[BW-1:0]];
  end

  assign sts.fat_q = fat_q_r;
  assign sts.buf_q = buf_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sector_r <= 28'd33;
      shift_r        <= 3'd0;
      limit_r        <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        fcca_pkg::CFG_FIRST_SECTOR: first_sector_r <= cfg_data;
        fcca_pkg::CFG_SHIFT:        shift_r        <= cfg_data[2:0];
        fcca_pkg::CFG_LIMIT:        limit_r        <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign cluster_limit = limit_r;

  assign sector_nxt = first_sector_r
                    + ((28'(cmd.emit_cluster) - 28'd2) << shift_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == fcca_pkg::OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == fcca_pkg::OP_EMIT) begin
      out_r.chain_cluster  <= cmd.emit_cluster;
      out_r.sector_address <= cmd.emit_sector ? sector_nxt : 28'd0;
      out_r.entry_out      <= cmd.emit_entry;
      out_r.status         <= cmd.emit_status;
      out_r.last           <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: design/fcca_ctrl.sv
// ----------------------------------------------------------------------------
// fcca_ctrl
// command sequencer for load, read, walk and resize
// ----------------------------------------------------------------------------
module fcca_ctrl #(
  parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CHAIN     = fcca_pkg::MAX_CHAIN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  fcca_pkg::in_item_t in_item,
  output logic               busy,
  input  logic [12:0]        cluster_limit,
  output fcca_pkg::dp_cmd_t  cmd,
  input  fcca_pkg::dp_sts_t  sts
);

  localparam logic [12:0] TE = 13'(TABLE_ENTRIES);
  localparam logic [6:0]  MC = 7'(MAX_CHAIN);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_READ_W   = 14'b00000000000010,
    S_WALK_RD  = 14'b00000000000100,
    S_WALK_W   = 14'b00000000001000,
    S_KEEP_RD  = 14'b00000000010000,
    S_KEEP_W   = 14'b00000000100000,
    S_FREE_RD  = 14'b00000001000000,
    S_FREE_W   = 14'b00000010000000,
    S_SRCH_RD  = 14'b00000100000000,
    S_SRCH_W   = 14'b00001000000000,
    S_LINK_RD  = 14'b00010000000000,
    S_LINK_W   = 14'b00100000000000,
    S_OUT_RD   = 14'b01000000000000,
    S_OUT_W    = 14'b10000000000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [11:0] cur_r, cur_nxt;
  logic [6:0]  n_r, n_nxt;
  logic [6:0]  need_r, need_nxt;
  logic [12:0] steps_r, steps_nxt;
  logic [12:0] bound_r, bound_nxt;
  logic [11:0] prev_r, prev_nxt;
  logic [11:0] q;
  logic [11:0] bq;
  logic [6:0]  cnt_sat;

  assign q  = sts.fat_q;
  assign bq = sts.buf_q;
  assign cnt_sat = (in_item.cluster_count > MC) ? MC : in_item.cluster_count;
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cur_r   <= cur_nxt;
    n_r     <= n_nxt;
    need_r  <= need_nxt;
    steps_r <= steps_nxt;
    bound_r <= bound_nxt;
    prev_r  <= prev_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    n_nxt     = n_r;
    need_nxt  = need_r;
    steps_nxt = steps_r;
    bound_nxt = bound_r;
    prev_nxt  = prev_r;
    cmd       = '0;
    cmd.op    = fcca_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cur_nxt   = in_item.cluster_index;
          n_nxt     = 7'd0;
          need_nxt  = cnt_sat;
          steps_nxt = 13'd0;
          bound_nxt = (cluster_limit < TE) ? cluster_limit : TE;
          if ({1'b0, in_item.cluster_index} >= TE) begin
            cmd.op = fcca_pkg::OP_EMIT;
            cmd.emit_status = fcca_pkg::ST_RANGE;
            cmd.emit_last = 1'b1;
          end else begin
            case (in_item.command)
              fcca_pkg::CMD_LOAD: begin
                cmd.op = fcca_pkg::OP_FAT_WR;
                cmd.fat_addr = in_item.cluster_index;
                cmd.fat_data = in_item.entry_in;
                state_nxt = S_OUT_W;
                prev_nxt = 12'd0;
              end
              fcca_pkg::CMD_READ: begin
                cmd.op = fcca_pkg::OP_FAT_RD;
                cmd.fat_addr = in_item.cluster_index;
                state_nxt = S_READ_W;
              end
              fcca_pkg::CMD_WALK: state_nxt = S_WALK_RD;
              default: begin
                if (in_item.cluster_index != 12'd0) begin
                  state_nxt = (cnt_sat != 7'd0) ? S_KEEP_RD : S_FREE_RD;
                end else if (cnt_sat == 7'd0) begin
                  cmd.op = fcca_pkg::OP_EMIT;
                  cmd.emit_last = 1'b1;
                end else begin
                  cur_nxt = 12'd2;
                  state_nxt = S_SRCH_RD;
                end
              end
            endcase
          end
        end
      end
      S_OUT_W: begin
        // single-result finish for load
        cmd.op = fcca_pkg::OP_EMIT;
        cmd.emit_last = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ_W: begin
        cmd.op = fcca_pkg::OP_EMIT;
        cmd.emit_entry = q;
        cmd.emit_last = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WALK_RD: begin
        cmd.op = fcca_pkg::OP_BUF_WR;
        cmd.fat_addr = cur_r;
        cmd.buf_addr = n_r[5:0];
        cmd.buf_data = cur_r;
        state_nxt = S_WALK_W;
      end
      S_WALK_W: begin
        cmd.op = fcca_pkg::OP_EMIT;
        cmd.emit_cluster = cur_r;
        cmd.emit_sector = 1'b1;
        n_nxt = n_r + 7'd1;
        cur_nxt = q;
        state_nxt = S_WALK_RD;
        if (q >= fcca_pkg::END_MARK) begin
          cmd.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end else if ({1'b0, q} >= TE) begin
          cmd.emit_last = 1'b1;
          cmd.emit_status = fcca_pkg::ST_RANGE;
          state_nxt = S_IDLE;
        end else if (n_r + 7'd1 >= MC) begin
          cmd.emit_last = 1'b1;
          cmd.emit_status = fcca_pkg::ST_TRUNC;
          state_nxt = S_IDLE;
        end
      end
      S_KEEP_RD: begin
        cmd.op = fcca_pkg::OP_BUF_WR;
        cmd.fat_addr = cur_r;
        cmd.buf_addr = n_r[5:0];
        cmd.buf_data = cur_r;
        state_nxt = S_KEEP_W;
      end
      S_KEEP_W: begin
        n_nxt = n_r + 7'd1;
        cur_nxt = q;
        if (q >= fcca_pkg::END_MARK || {1'b0, q} >= TE) begin
          cur_nxt = 12'd2;
          state_nxt = S_SRCH_RD;
        end else if (n_r + 7'd1 >= need_r) begin
          state_nxt = S_FREE_RD;
        end else begin
          state_nxt = S_KEEP_RD;
        end
      end
      S_FREE_RD: begin
        if (cur_r >= 12'd2 && {1'b0, cur_r} < TE && cur_r < fcca_pkg::END_MARK
            && steps_r < TE) begin
          cmd.op = fcca_pkg::OP_FAT_RD;
          cmd.fat_addr = cur_r;
          state_nxt = S_FREE_W;
        end else if (need_r == 7'd0) begin
          cmd.op = fcca_pkg::OP_EMIT;
          cmd.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cur_nxt = 12'd2;
          state_nxt = S_SRCH_RD;
        end
      end
      S_FREE_W: begin
        cmd.op = fcca_pkg::OP_FAT_WR;
        cmd.fat_addr = cur_r;
        cmd.fat_data = fcca_pkg::FREE_ENTRY;
        cur_nxt = q;
        steps_nxt = steps_r + 13'd1;
        state_nxt = S_FREE_RD;
      end
      S_SRCH_RD: begin
        if (n_r >= need_r) begin
          n_nxt = 7'd0;
          state_nxt = S_LINK_RD;
        end else if ({1'b0, cur_r} >= bound_r) begin
          cmd.op = fcca_pkg::OP_EMIT;
          cmd.emit_status = fcca_pkg::ST_FULL;
          cmd.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = fcca_pkg::OP_FAT_RD;
          cmd.fat_addr = cur_r;
          state_nxt = S_SRCH_W;
        end
      end
      S_SRCH_W: begin
        if (q == fcca_pkg::FREE_ENTRY) begin
          cmd.op = fcca_pkg::OP_BUF_WR;
          cmd.buf_addr = n_r[5:0];
          cmd.buf_data = cur_r;
          n_nxt = n_r + 7'd1;
        end
        cur_nxt = cur_r + 12'd1;
        if (cur_r == 12'hFFF) begin
          bound_nxt = 13'd0;
        end
        state_nxt = S_SRCH_RD;
      end
      S_LINK_RD: begin
        cmd.op = fcca_pkg::OP_BUF_RD;
        cmd.buf_addr = n_r[5:0];
        state_nxt = S_LINK_W;
      end
      S_LINK_W: begin
        // bq is buffer entry n; link previous entry to it
        if (n_r != 7'd0) begin
          cmd.op = fcca_pkg::OP_FAT_WR;
          cmd.fat_addr = prev_r;
          cmd.fat_data = bq;
        end
        prev_nxt = bq;
        n_nxt = n_r + 7'd1;
        if (n_r + 7'd1 >= need_r) begin
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_LINK_RD;
        end
      end
      S_OUT_RD: begin
        if (n_r == need_r) begin
          cmd.op = fcca_pkg::OP_FAT_WR;
          cmd.fat_addr = prev_r;
          cmd.fat_data = fcca_pkg::END_WRITE;
          n_nxt = 7'd0;
          steps_nxt = 13'd1;
        end else begin
          cmd.op = fcca_pkg::OP_BUF_RD;
          cmd.buf_addr = n_r[5:0];
          state_nxt = S_OUT_W;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // emission phase of a resize reuses S_OUT_W with steps_r flag
    if (state_r == S_OUT_W && steps_r == 13'd1) begin
      cmd = '0;
      cmd.op = fcca_pkg::OP_EMIT;
      cmd.emit_cluster = bq;
      cmd.emit_sector = 1'b1;
      n_nxt = n_r + 7'd1;
      if (n_r + 7'd1 >= need_r) begin
        cmd.emit_last = 1'b1;
        state_nxt = S_IDLE;
        steps_nxt = 13'd0;
      end else begin
        state_nxt = S_OUT_RD;
      end
    end
  end

endmodule

FILE: bench/fat_cluster_chain_allocator_test.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_test
// The bench loads a low region of the table first and keeps every link and
// every free search inside written entries. It then runs directed commands
// and random commands under several register settings, the extremes among
// them. A predictor class keeps its own copy of the table and computes the
// expected results. Every strobed result is checked against the oldest
// expected one, field by field.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 500000;
  localparam int REGION       = 64;

  class chain_predictor;
    logic [11:0] fat [4096];
    logic [11:0] chain [64];
    logic [27:0] first_sector;
    logic [2:0]  shift;
    logic [12:0] limit;
    fcca_pkg::out_item_t pending_results[$];
    int          errors;

    function new();
      first_sector = 28'd33;
      shift = 3'd0;
      limit = 13'd4096;
      errors = 0;
      foreach (fat[i]) fat[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [27:0] data);
      case (idx)
        fcca_pkg::CFG_FIRST_SECTOR: first_sector = data;
        fcca_pkg::CFG_SHIFT:        shift = data[2:0];
        fcca_pkg::CFG_LIMIT:        limit = data[12:0];
        default: ;
      endcase
    endfunction

    function logic [27:0] sector_of(logic [11:0] c);
      logic [27:0] d;
      logic [63:0] off;
      d = 28'(c) - 28'd2;
      off = 64'(d) << shift;
      return 28'(off + 64'(first_sector));
    endfunction

    function void push(logic [11:0] cl, logic [27:0] sec, logic [11:0] ent,
                       logic [1:0] st, logic lst);
      fcca_pkg::out_item_t r;
      r.chain_cluster = cl;
      r.sector_address = sec;
      r.entry_out = ent;
      r.status = st;
      r.last = lst;
      pending_results.push_back(r);
    endfunction

    function void walk(logic [11:0] start_c);
      logic [11:0] cur;
      logic [11:0] nxt;
      int n;
      cur = start_c;
      n = 0;
      forever begin
        n++;
        nxt = fat[cur];
        if (nxt >= fcca_pkg::END_MARK) begin
          push(cur, sector_of(cur), '0, fcca_pkg::ST_OK, 1'b1);
          break;
        end
        if (n >= 64) begin
          push(cur, sector_of(cur), '0, fcca_pkg::ST_TRUNC, 1'b1);
          break;
        end
        push(cur, sector_of(cur), '0, fcca_pkg::ST_OK, 1'b0);
        cur = nxt;
      end
    endfunction

    function void resize(logic [11:0] start_c, logic [6:0] cnt);
      int need, kept, got, steps, bound;
      logic [11:0] cur;
      logic [11:0] nxt;
      bit ended;
      need = (cnt > 64) ? 64 : int'(cnt);
      kept = 0;
      cur = start_c;
      ended = 0;
      if (start_c != 0) begin
        if (need > 0) begin
          forever begin
            chain[kept] = cur;
            kept++;
            cur = fat[cur];
            if (cur >= fcca_pkg::END_MARK) begin
              ended = 1;
              break;
            end
            if (kept >= need) break;
          end
        end
        if (!ended) begin
          steps = 0;
          while (cur >= 2 && cur < fcca_pkg::END_MARK && steps < 4096) begin
            nxt = fat[cur];
            fat[cur] = fcca_pkg::FREE_ENTRY;
            cur = nxt;
            steps++;
          end
        end
      end
      if (need == 0) begin
        push('0, '0, '0, fcca_pkg::ST_OK, 1'b1);
        return;
      end
      bound = (limit < 4096) ? int'(limit) : 4096;
      got = kept;
      for (int i = 2; i < bound && got < need; i++) begin
        if (fat[i] == fcca_pkg::FREE_ENTRY) begin
          chain[got] = 12'(i);
          got++;
        end
      end
      if (got < need) begin
        push('0, '0, '0, fcca_pkg::ST_FULL, 1'b1);
        return;
      end
      for (int k = 0; k + 1 < need; k++) fat[chain[k]] = chain[k + 1];
      fat[chain[need - 1]] = fcca_pkg::END_WRITE;
      for (int k = 0; k < need; k++)
        push(chain[k], sector_of(chain[k]), '0, fcca_pkg::ST_OK, k + 1 == need);
    endfunction

    function void note(fcca_pkg::in_item_t it);
      case (it.command)
        fcca_pkg::CMD_LOAD: begin
          fat[it.cluster_index] = it.entry_in;
          push('0, '0, '0, fcca_pkg::ST_OK, 1'b1);
        end
        fcca_pkg::CMD_READ:
          push('0, '0, fat[it.cluster_index], fcca_pkg::ST_OK, 1'b1);
        fcca_pkg::CMD_WALK: walk(it.cluster_index);
        default:  resize(it.cluster_index, it.cluster_count);
      endcase
    endfunction

    function void check(fcca_pkg::out_item_t got);
      fcca_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.chain_cluster !== want.chain_cluster) begin
        $error("chain_cluster exp %0h got %0h", want.chain_cluster, got.chain_cluster);
        errors++;
      end
      if (got.sector_address !== want.sector_address) begin
        $error("sector_address exp %0h got %0h", want.sector_address,
               got.sector_address);
        errors++;
      end
      if (got.entry_out !== want.entry_out) begin
        $error("entry_out exp %0h got %0h", want.entry_out, got.entry_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status exp %0d got %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last exp %0d got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  fcca_pkg::in_item_t  in_item;
  logic                out_valid;
  fcca_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [27:0]         cfg_data;

  chain_predictor pred;
  int unsigned    cycles;

  fat_cluster_chain_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial pred = new();

  always @(posedge clk) begin
    if (rst_n && out_valid) pred.check(out_item);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[fat_cluster_chain_allocator] ERROR");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic issue(logic [1:0] cmd, logic [11:0] idx, logic [11:0] ent,
                       logic [6:0] cnt);
    in_item.command = cmd;
    in_item.cluster_index = idx;
    in_item.entry_in = ent;
    in_item.cluster_count = cnt;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pred.note(in_item);
    @(negedge clk);
  endtask

  task automatic pause(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pred.pending_results.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [27:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    pred.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // indexes and links stay inside the loaded region or the top entry
  function automatic logic [11:0] pick_index();
    return ($urandom_range(0, 15) == 0) ? 12'hFFF : 12'($urandom_range(0, REGION - 1));
  endfunction

  function automatic logic [11:0] pick_value();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return fcca_pkg::FREE_ENTRY;
    if (r == 1) return 12'($urandom_range(32'hFF8, 32'hFFF));
    return 12'($urandom_range(0, REGION - 1));
  endfunction

  task automatic random_burst(int n);
    int pick;
    int len;
    int sent;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len && sent < n; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3)
          issue(fcca_pkg::CMD_LOAD, 12'($urandom_range(0, REGION - 1)), pick_value(),
                7'($urandom));
        else if (pick < 4)
          issue(fcca_pkg::CMD_READ, pick_index(), 12'($urandom), 7'($urandom));
        else if (pick < 6)
          issue(fcca_pkg::CMD_WALK, pick_index(), 12'($urandom), 7'($urandom));
        else
          issue(fcca_pkg::CMD_RESIZE,
                ($urandom_range(0, 2) == 0) ? 12'd0 : pick_index(), 12'($urandom),
                ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 8)));
        sent++;
      end
      pause($urandom_range(1, 10));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = fcca_pkg::CFG_FIRST_SECTOR;
    cfg_data = '0;
    cycles = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < REGION; i++)
      issue(fcca_pkg::CMD_LOAD, 12'(i), fcca_pkg::FREE_ENTRY, 7'($urandom));
    issue(fcca_pkg::CMD_LOAD, 12'hFFF, 12'hFFF, 7'h7F);
    drain();
    write_reg(fcca_pkg::CFG_FIRST_SECTOR, 28'd33);
    write_reg(fcca_pkg::CFG_SHIFT, 28'd0);
    write_reg(fcca_pkg::CFG_LIMIT, 28'(REGION));

    issue(fcca_pkg::CMD_READ, 12'hFFF, 12'h000, 7'h00);
    issue(fcca_pkg::CMD_LOAD, 12'd1, fcca_pkg::END_MARK, 7'd0);
    issue(fcca_pkg::CMD_READ, 12'd1, 12'h555, 7'd0);
    issue(fcca_pkg::CMD_WALK, 12'hFFF, 12'h000, 7'd0);
    issue(fcca_pkg::CMD_LOAD, 12'd10, 12'd11, 7'd0);
    issue(fcca_pkg::CMD_LOAD, 12'd11, 12'd12, 7'd0);
    issue(fcca_pkg::CMD_LOAD, 12'd12, fcca_pkg::END_MARK, 7'd0);
    issue(fcca_pkg::CMD_WALK, 12'd10, 12'd0, 7'd0);
    issue(fcca_pkg::CMD_LOAD, 12'd20, 12'd21, 7'd0);
    issue(fcca_pkg::CMD_LOAD, 12'd21, 12'd20, 7'd0);
    issue(fcca_pkg::CMD_WALK, 12'd20, 12'd0, 7'd0);
    issue(fcca_pkg::CMD_LOAD, 12'd30, 12'd1, 7'd0);
    issue(fcca_pkg::CMD_WALK, 12'd30, 12'd0, 7'd0);
    issue(fcca_pkg::CMD_WALK, 12'd0, 12'd0, 7'd0);
    issue(fcca_pkg::CMD_RESIZE, 12'd10, 12'd0, 7'd1);
    issue(fcca_pkg::CMD_RESIZE, 12'd10, 12'd0, 7'd5);
    issue(fcca_pkg::CMD_WALK, 12'd10, 12'd0, 7'd0);
    issue(fcca_pkg::CMD_RESIZE, 12'd10, 12'd0, 7'd0);
    issue(fcca_pkg::CMD_RESIZE, 12'd0, 12'd0, 7'd3);
    issue(fcca_pkg::CMD_RESIZE, 12'd0, 12'd0, 7'h7F);
    issue(fcca_pkg::CMD_RESIZE, 12'd20, 12'd0, 7'd2);
    issue(fcca_pkg::CMD_RESIZE, 12'd30, 12'd0, 7'd3);
    drain();

    write_reg(fcca_pkg::CFG_FIRST_SECTOR, 28'hFFFFFFF);
    write_reg(fcca_pkg::CFG_SHIFT, 28'd7);
    write_reg(fcca_pkg::CFG_LIMIT, 28'd2);
    issue(fcca_pkg::CMD_RESIZE, 12'd0, 12'd0, 7'd1);
    issue(fcca_pkg::CMD_WALK, 12'd0, 12'd0, 7'd0);
    issue(fcca_pkg::CMD_WALK, 12'hFFF, 12'd0, 7'd0);
    drain();
    write_reg(fcca_pkg::CFG_LIMIT, 28'd8191);
    issue(fcca_pkg::CMD_RESIZE, 12'd0, 12'd0, 7'd2);
    drain();

    write_reg(fcca_pkg::CFG_FIRST_SECTOR, 28'($urandom));
    write_reg(fcca_pkg::CFG_SHIFT, 28'($urandom_range(0, 7)));
    write_reg(fcca_pkg::CFG_LIMIT, 28'($urandom_range(2, REGION)));
    random_burst(10);
    drain();

    write_reg(fcca_pkg::CFG_FIRST_SECTOR, 28'd0);
    write_reg(fcca_pkg::CFG_SHIFT, 28'd3);
    write_reg(fcca_pkg::CFG_LIMIT, 28'(REGION));
    random_burst(10);
    drain();
    repeat (200) @(posedge clk);

    if (pred.errors == 0 && pred.pending_results.size() == 0) begin
      $display("[fat_cluster_chain_allocator] OK");
    end else begin
      $display("[fat_cluster_chain_allocator] ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/fcca_pkg.sv
design/fcca_datapath.sv
design/fcca_ctrl.sv
design/fat_cluster_chain_allocator.sv
bench/fat_cluster_chain_allocator_test.sv
